// ===== design/hmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash map package
// Sizes, slot and result codes, memory word layout and the home slot hash
// shared by the hash map table and its slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package hmlp_pkg;

    // The slot count is a power of two, so the home slot is a bit-select.
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = 11;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(819);

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_USED  = 2'd1,
        SL_TOMB  = 2'd2
    } t_slot_state;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET    = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        RS_INSERTED = 3'd0,
        RS_UPDATED  = 3'd1,
        RS_FOUND    = 3'd2,
        RS_MISSING  = 3'd3,
        RS_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_slot_state      st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_slot;

    typedef struct packed {
        logic      en;
        t_slot_idx addr;
        t_slot     word;
    } t_wr_req;

    function automatic t_slot_idx home_slot(input logic [KEY_W-1:0] key);
        logic [31:0] h;
        h = key[31:0] ^ key[63:32];
        return h[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/hmlp_if.sv =====
// ----------------------------------------------------------------------------
// Hash map channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmlp_req_if;
    logic                         valid;
    logic                         ready;
    logic [hmlp_pkg::FUNC_W-1:0]  func;
    logic [hmlp_pkg::KEY_W-1:0]   key;
    logic [hmlp_pkg::VAL_W-1:0]   value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface hmlp_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hmlp_pkg::STAT_W-1:0]  status;
    logic [hmlp_pkg::VAL_W-1:0]   data;
    logic [hmlp_pkg::CNT_W-1:0]   live_count;

    modport source (output valid, output status, output data, output live_count,
                    input ready);
    modport sink   (input valid, input status, input data, input live_count,
                    output ready);
endinterface

interface hmlp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hmlp_pkg::CNT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/hmlp_store.sv =====
// ----------------------------------------------------------------------------
// Hash map slot store
// Single memory holding slot state, key and value, with one write port and
// one read port whose data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hmlp_store (
    input  wire                  i_clk,
    input  hmlp_pkg::t_slot_idx  i_rd_addr,
    output hmlp_pkg::t_slot      o_rd_data,
    input  hmlp_pkg::t_wr_req    i_wr
);

    hmlp_pkg::t_slot r_mem [hmlp_pkg::SLOTS];
    hmlp_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.word;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/hash_map_linear_probe_top.sv =====
// ----------------------------------------------------------------------------
// Hash map with linear probing
// Open addressing key-value table: set, get and remove of 64-bit keys with
// tombstones, a load limit and a clearing pass when the table empties.
//
//   Channel   Direction  Word
//   i_req     in         func, key, value
//   o_rsp     out        status, data, live_count
//   i_cfg     in         load limit
//
// Each request probes P slots, starting at its home slot, before its response;
// P is 1 to 1024, and the probe reads one slot per cycle.
// After reset, and after a remove that leaves no live entry, a clearing pass
// writes every slot empty, during which no request is taken.
// A response waits in an output register; a new request is accepted while it
// waits, and the table stalls only when a second response is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_map_linear_probe_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    hmlp_req_if.sink    i_req,
    hmlp_rsp_if.source  o_rsp,
    hmlp_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_PROBE = 4'b0100,
        S_ACT   = 4'b1000
    } t_state;

    localparam hmlp_pkg::t_slot_idx LAST_IDX = hmlp_pkg::t_slot_idx'(hmlp_pkg::SLOTS - 1);

    t_state                         r_state, n_state;
    logic [hmlp_pkg::CNT_W-1:0]     r_limit;
    logic [hmlp_pkg::CNT_W-1:0]     r_count, n_count;
    hmlp_pkg::t_slot_idx            r_clr_idx, n_clr_idx;
    hmlp_pkg::t_slot_idx            r_cur, n_cur;
    hmlp_pkg::t_slot_idx            r_n, n_n;
    logic [hmlp_pkg::FUNC_W-1:0]    r_func, n_func;
    logic [hmlp_pkg::KEY_W-1:0]     r_key, n_key;
    logic [hmlp_pkg::VAL_W-1:0]     r_val, n_val;
    logic                           r_hit, n_hit;
    hmlp_pkg::t_slot_idx            r_hit_idx, n_hit_idx;
    logic [hmlp_pkg::VAL_W-1:0]     r_hit_val, n_hit_val;
    logic                           r_free_ok, n_free_ok;
    hmlp_pkg::t_slot_idx            r_free_idx, n_free_idx;

    logic                           r_rsp_valid, n_rsp_valid;
    logic [hmlp_pkg::STAT_W-1:0]    r_status, n_status;
    logic [hmlp_pkg::VAL_W-1:0]     r_data, n_data;
    logic [hmlp_pkg::CNT_W-1:0]     r_live, n_live;

    hmlp_pkg::t_slot_idx            rd_addr;
    hmlp_pkg::t_slot                rd_data;
    hmlp_pkg::t_wr_req              wr;
    logic                           req_fire;
    logic                           out_free;

    hmlp_store u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_rsp_valid || o_rsp.ready;

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.data       = r_data;
    assign o_rsp.live_count = r_live;

    // The probe reads ahead one slot each cycle; no write happens while probing.
    assign rd_addr = (r_state == S_IDLE) ? hmlp_pkg::home_slot(i_req.key)
                                         : r_cur + hmlp_pkg::t_slot_idx'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_cur       = r_cur;
        n_n         = r_n;
        n_func      = r_func;
        n_key       = r_key;
        n_val       = r_val;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_val   = r_hit_val;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_status    = r_status;
        n_data      = r_data;
        n_live      = r_live;
        wr.en       = 1'b0;
        wr.addr     = r_hit_idx;
        wr.word.st  = hmlp_pkg::SL_USED;
        wr.word.key = r_key;
        wr.word.val = r_val;

        unique case (r_state)
            S_CLEAR: begin
                wr.en       = 1'b1;
                wr.addr     = r_clr_idx;
                wr.word.st  = hmlp_pkg::SL_EMPTY;
                wr.word.key = '0;
                wr.word.val = '0;
                n_clr_idx   = r_clr_idx + hmlp_pkg::t_slot_idx'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_func    = i_req.func;
                    n_key     = i_req.key;
                    n_val     = i_req.value;
                    n_cur     = hmlp_pkg::home_slot(i_req.key);
                    n_n       = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                n_cur = r_cur + hmlp_pkg::t_slot_idx'(1);
                n_n   = r_n + hmlp_pkg::t_slot_idx'(1);
                if (rd_data.st == hmlp_pkg::SL_USED) begin
                    if (rd_data.key == r_key) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cur;
                        n_hit_val = rd_data.val;
                        n_state   = S_ACT;
                    end
                end else begin
                    if (!r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_cur;
                    end
                    if (rd_data.st == hmlp_pkg::SL_EMPTY) begin
                        n_state = S_ACT;
                    end
                end
                if (r_n == LAST_IDX) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (out_free) begin
                    n_rsp_valid = 1'b1;
                    n_status    = hmlp_pkg::RS_MISSING;
                    n_data      = '0;
                    n_state     = S_IDLE;
                    case (r_func)
                        hmlp_pkg::FN_SET: begin
                            if (r_hit) begin
                                wr.en    = 1'b1;
                                n_status = hmlp_pkg::RS_UPDATED;
                            end else if (r_count >= r_limit || !r_free_ok) begin
                                n_status = hmlp_pkg::RS_FULL;
                            end else begin
                                wr.en    = 1'b1;
                                wr.addr  = r_free_idx;
                                n_count  = r_count + hmlp_pkg::CNT_W'(1);
                                n_status = hmlp_pkg::RS_INSERTED;
                            end
                        end
                        hmlp_pkg::FN_GET: begin
                            if (r_hit) begin
                                n_data   = r_hit_val;
                                n_status = hmlp_pkg::RS_FOUND;
                            end
                        end
                        hmlp_pkg::FN_REMOVE: begin
                            if (r_hit) begin
                                wr.en       = 1'b1;
                                wr.word.st  = hmlp_pkg::SL_TOMB;
                                wr.word.val = r_hit_val;
                                n_data      = r_hit_val;
                                n_status    = hmlp_pkg::RS_FOUND;
                                if (r_count != '0) begin
                                    n_count = r_count - hmlp_pkg::CNT_W'(1);
                                end
                                if (r_count <= hmlp_pkg::CNT_W'(1)) begin
                                    n_clr_idx = '0;
                                    n_state   = S_CLEAR;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_live = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_limit     <= hmlp_pkg::LIMIT_RESET;
            r_rsp_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            r_hit       <= n_hit;
            r_free_ok   <= n_free_ok;
            r_n         <= n_n;
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_func     <= n_func;
        r_key      <= n_key;
        r_val      <= n_val;
        r_hit_idx  <= n_hit_idx;
        r_hit_val  <= n_hit_val;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_data     <= n_data;
        r_live     <= n_live;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Hash map with linear probing: testbench
// Drives set, get and remove words into the table and checks every response
// against a shadow table kept in the testbench. A short directed part covers
// collisions, wrap-around, tombstones, the unused function code and the load
// limit at zero and one. Random phases follow at several load limits,
// including a phase that fills all slots so that probes run the whole table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import hmlp_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } hm_req_t;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  data;
        logic [CNT_W-1:0]  live_count;
    } hm_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hmlp_req_if req_bus ();
    hmlp_rsp_if rsp_bus ();
    hmlp_cfg_if cfg_bus ();

    hash_map_linear_probe_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    t_slot_state      shadow_state [SLOTS];
    logic [KEY_W-1:0] shadow_key   [SLOTS];
    logic [VAL_W-1:0] shadow_val   [SLOTS];
    int               shadow_live;
    int               shadow_limit;

    hm_req_t          request_queue[$];
    hm_rsp_t          pending_responses[$];
    logic [KEY_W-1:0] key_pool[$];

    bit allow_stalls;
    bit req_fired;
    int req_gap;
    int rsp_gap;
    int mismatches;
    int rsp_seen;
    int full_refusals;
    int table_clears;
    int func_seen [4];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void probe_shadow(input logic [KEY_W-1:0] k, output int hit,
                                         output int vacant);
        logic [31:0] h;
        int          idx;
        bit          stop;
        h      = k[31:0] ^ k[63:32];
        idx    = int'(h % SLOTS);
        hit    = -1;
        vacant = -1;
        stop   = 1'b0;
        for (int n = 0; n < SLOTS && !stop; n++) begin
            if (shadow_state[idx] == SL_USED) begin
                if (shadow_key[idx] == k) begin
                    hit  = idx;
                    stop = 1'b1;
                end
            end else begin
                if (vacant < 0) vacant = idx;
                if (shadow_state[idx] == SL_EMPTY) stop = 1'b1;
            end
            idx = (idx + 1) % SLOTS;
        end
    endfunction

    function automatic hm_rsp_t apply_request(input hm_req_t rq);
        hm_rsp_t r;
        int      hit;
        int      vacant;
        r.status = RS_MISSING;
        r.data   = '0;
        probe_shadow(rq.key, hit, vacant);
        case (rq.func)
            FN_SET: begin
                if (hit >= 0) begin
                    shadow_val[hit] = rq.value;
                    r.status = RS_UPDATED;
                end else if (shadow_live + 1 > shadow_limit || vacant < 0) begin
                    r.status = RS_FULL;
                    full_refusals++;
                end else begin
                    shadow_state[vacant] = SL_USED;
                    shadow_key[vacant]   = rq.key;
                    shadow_val[vacant]   = rq.value;
                    shadow_live++;
                    r.status = RS_INSERTED;
                end
            end
            FN_GET: begin
                if (hit >= 0) begin
                    r.data   = shadow_val[hit];
                    r.status = RS_FOUND;
                end
            end
            FN_REMOVE: begin
                if (hit >= 0) begin
                    r.data   = shadow_val[hit];
                    r.status = RS_FOUND;
                    shadow_state[hit] = SL_TOMB;
                    if (shadow_live > 0) shadow_live--;
                    if (shadow_live == 0) begin
                        foreach (shadow_state[i]) shadow_state[i] = SL_EMPTY;
                        table_clears++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.live_count = CNT_W'(shadow_live);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] key_with_home(input int unsigned home);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        lo[SLOT_W-1:0] = hi[SLOT_W-1:0] ^ home[SLOT_W-1:0];
        return {hi, lo};
    endfunction

    function automatic void queue_request(input logic [FUNC_W-1:0] fn,
                                          input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
        hm_req_t rq;
        rq.func  = fn;
        rq.key   = k;
        rq.value = v;
        request_queue.push_back(rq);
    endfunction

    function automatic void queue_mixed(input int count, input int home_lo,
                                        input int home_span, input int pct_set,
                                        input int pct_get, input int pct_rem);
        int                roll;
        logic [FUNC_W-1:0] fn;
        logic [KEY_W-1:0]  k;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < pct_set) fn = FN_SET;
            else if (roll < pct_set + pct_get) fn = FN_GET;
            else if (roll < pct_set + pct_get + pct_rem) fn = FN_REMOVE;
            else fn = FN_UNUSED;
            if (key_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
                k = key_with_home((home_lo + $urandom_range(0, home_span - 1)) % SLOTS);
                key_pool.push_back(k);
            end
            queue_request(fn, k, {$urandom, $urandom});
        end
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endtask

    task automatic wait_until_drained();
        while (request_queue.size() != 0 || req_bus.valid || pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] lim);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= lim;
        do @(posedge i_clk); while (!cfg_bus.ready);
        shadow_limit = int'(lim);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Request driver.
    always @(negedge i_clk) begin
        if (!req_bus.valid || req_fired) begin
            req_fired = 1'b0;
            if (req_gap > 0) begin
                req_gap--;
                req_bus.valid <= 1'b0;
            end else if (allow_stalls && $urandom_range(0, 7) == 0) begin
                req_gap = $urandom_range(0, 9);
                req_bus.valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                hm_req_t rq;
                rq = request_queue.pop_front();
                req_bus.valid <= 1'b1;
                req_bus.func  <= rq.func;
                req_bus.key   <= rq.key;
                req_bus.value <= rq.value;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Response ready with random stall bursts.
    always @(negedge i_clk) begin
        if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
        end else if (allow_stalls && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 9);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Monitor: checks responses first, then predicts for the word taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_seen++;
                if (pending_responses.size() == 0) begin
                    log_mismatch($sformatf("response %0d arrived with nothing pending",
                                           rsp_seen));
                end else begin
                    hm_rsp_t exp;
                    exp = pending_responses.pop_front();
                    if (rsp_bus.status !== exp.status || rsp_bus.data !== exp.data ||
                        rsp_bus.live_count !== exp.live_count)
                        log_mismatch($sformatf(
                            "response %0d: status %0d/%0d data %h/%h live %0d/%0d (exp/act)",
                            rsp_seen, exp.status, rsp_bus.status, exp.data, rsp_bus.data,
                            exp.live_count, rsp_bus.live_count));
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                hm_req_t rq;
                rq.func  = req_bus.func;
                rq.key   = req_bus.key;
                rq.value = req_bus.value;
                pending_responses.push_back(apply_request(rq));
                func_seen[rq.func]++;
                req_fired = 1'b1;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] k_zero;
        logic [KEY_W-1:0] k_ones;
        logic [KEY_W-1:0] k_col;
        logic [KEY_W-1:0] k_miss;
        logic [KEY_W-1:0] k_end;
        logic [KEY_W-1:0] k_wrap;
        logic [KEY_W-1:0] k;

        req_bus.valid  = 1'b0;
        req_bus.func   = '0;
        req_bus.key    = '0;
        req_bus.value  = '0;
        rsp_bus.ready  = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        allow_stalls   = 1'b1;
        foreach (shadow_state[i]) begin
            shadow_state[i] = SL_EMPTY;
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
        end
        shadow_live  = 0;
        shadow_limit = int'(LIMIT_RESET);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All of these keys but the last two hash to slot zero; those two hash
        // to the last slot, so the second one wraps around the table.
        k_zero = '0;
        k_ones = '1;
        k_col  = 64'h0000_0001_0000_0001;
        k_miss = 64'h0000_0002_0000_0002;
        k_end  = 64'h0000_0000_0000_03FF;
        k_wrap = 64'h0000_0001_0000_03FE;

        queue_request(FN_GET,    k_zero, '0);
        queue_request(FN_SET,    k_zero, '1);
        queue_request(FN_SET,    k_ones, '0);
        queue_request(FN_SET,    k_col,  64'h0123_4567_89AB_CDEF);
        queue_request(FN_GET,    k_ones, '1);
        queue_request(FN_SET,    k_zero, 64'h5555_5555_5555_5555);
        queue_request(FN_REMOVE, k_zero, '0);
        queue_request(FN_SET,    k_col,  64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(FN_GET,    k_col,  '0);
        queue_request(FN_REMOVE, k_miss, '0);
        queue_request(FN_SET,    k_zero, 64'h1);
        queue_request(FN_UNUSED, k_ones, '1);
        queue_request(FN_SET,    k_end,  '1);
        queue_request(FN_SET,    k_wrap, 64'h8000_0000_0000_0000);
        queue_request(FN_GET,    k_wrap, '0);
        queue_request(FN_REMOVE, k_zero, '0);
        queue_request(FN_REMOVE, k_ones, '0);
        queue_request(FN_REMOVE, k_col,  '0);
        queue_request(FN_REMOVE, k_end,  '0);
        queue_request(FN_REMOVE, k_wrap, '0);
        wait_until_drained();

        write_limit(CNT_W'(0));
        queue_request(FN_SET, k_zero, '1);
        wait_until_drained();

        write_limit(CNT_W'(1));
        queue_request(FN_SET,    k_zero, 64'h0F0F_0F0F_0F0F_0F0F);
        queue_request(FN_SET,    k_ones, '1);
        queue_request(FN_SET,    k_zero, 64'hF0F0_F0F0_F0F0_F0F0);
        queue_request(FN_REMOVE, k_zero, '0);
        wait_until_drained();

        // Small limit, keys crowded around the wrap point of the table.
        write_limit(CNT_W'(8));
        key_pool.delete();
        queue_mixed(200, SLOTS - 4, 8, 45, 25, 25);
        wait_until_drained();

        // Largest limit: fill every slot, then work on a table with no empty slot.
        write_limit('1);
        key_pool.delete();
        for (int i = 0; i < SLOTS + 6; i++) begin
            k = key_with_home($urandom_range(0, SLOTS - 1));
            key_pool.push_back(k);
            queue_request(FN_SET, k, {$urandom, $urandom});
        end
        queue_mixed(60, 0, SLOTS, 25, 35, 35);
        wait_until_drained();

        write_limit(CNT_W'(SLOTS));
        queue_mixed(100, 0, SLOTS, 30, 20, 45);
        wait_until_drained();

        allow_stalls = 1'b0;
        write_limit(LIMIT_RESET);
        queue_mixed(100, 0, SLOTS, 30, 20, 45);
        wait_until_drained();
        repeat (40) @(posedge i_clk);

        $display("Words sent: %0d set, %0d get, %0d remove, %0d with the unused code.",
                 func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
        $display("Responses checked: %0d, of which %0d refused as full; table emptied %0d times.",
                 rsp_seen, full_refusals, table_clears);
        if (mismatches == 0 && pending_responses.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d responses missing.", mismatches,
                     pending_responses.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
